FILE: rtl/crtl_pkg.sv
package crtl_pkg;

  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_POSITION = 2'd2;
  localparam logic [1:0] STAT_NO_LINE  = 2'd3;

  localparam logic REG_LAST_COLUMN = 1'b0;
  localparam logic REG_LAST_ROW    = 1'b1;

  localparam logic [11:0] LIMIT_MAX = 12'd4095;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/clip_and_rasterize_thick_line_top.sv
// Clip and rasterize a thick line.
// Input stream s_*: s_tuser[0] selects load (0) or advance (1); a load carries
// both endpoints in s_tdata as signed Q23.8. Output stream m_*: one result
// per input, m_tuser is the status, m_tlast marks the final line position.
// Configuration: cfg_we/cfg_index/cfg_data write last_column and last_row.
// A load clips each endpoint to each window edge using one shared shift-add
// multiplier and one restoring divider; a rejected segment skips the clips,
// and a clip whose quotient is not needed uses neither unit. An advance uses
// the divider, except when the span is zero or no segment is active. s_tready
// is high only while the sequencer is idle; one item is worked at a time.
// A finished result waits in the output register while the next item is
// taken; if the receiver still stalls when that item finishes, the
// sequencer holds until the register drains.
// Synchronous reset clears the segment and m_tvalid, and restores
// last_column to 639 and last_row to 479.
module clip_and_rasterize_thick_line_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // x_first, y_first, x_second, y_second
  input  logic [0:0]    s_tuser,   // action
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,   // major_is_x, column, row, zero fill
  output logic [1:0]    m_tuser,   // status
  output logic          m_tlast,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [11:0]   cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_LOAD     = 9'b000000010,
    ST_CLIP     = 9'b000000100,
    ST_CLIP_MUL = 9'b000001000,
    ST_CLIP_DIV = 9'b000010000,
    ST_FINISH   = 9'b000100000,
    ST_ADV      = 9'b001000000,
    ST_ADV_DIV  = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_t;

  state_t state;

  logic [11:0] last_column, last_row;
  logic signed [31:0] x1, y1, x2, y2;
  logic [2:0] idx;
  logic active, horizontal;
  logic [11:0] major_now, major_start, major_end, minor_start, minor_end;
  logic signed [25:0] n_prod;
  logic adv_neg;
  logic adv_fin;

  logic [1:0]  res_status;
  logic        res_mx, res_last;
  logic [11:0] res_col, res_row;

  logic [19:0] w, h;
  logic [11:0] col_lim, row_lim;
  assign col_lim = (last_column > crtl_pkg::LIMIT_MAX) ? crtl_pkg::LIMIT_MAX : last_column;
  assign row_lim = (last_row > crtl_pkg::LIMIT_MAX) ? crtl_pkg::LIMIT_MAX : last_row;
  assign w = {col_lim, 8'd0};
  assign h = {row_lim, 8'd0};

  logic signed [31:0] pa, pb, oa, ob;
  logic signed [33:0] bound, num, den;
  logic signed [32:0] db;
  logic [32:0] un, ud, mdb;
  logic cond, skip, take_other;

  always_comb begin
    case (idx[1:0])
      2'd0:    begin pa = x1; pb = y1; oa = x2; ob = y2; end
      2'd1:    begin pa = x2; pb = y2; oa = x1; ob = y1; end
      2'd2:    begin pa = y1; pb = x1; oa = y2; ob = x2; end
      default: begin pa = y2; pb = x2; oa = y1; ob = x1; end
    endcase
    if (!idx[2]) bound = '0;
    else if (!idx[1]) bound = $signed({14'd0, w});
    else bound = $signed({14'd0, h});
    cond = idx[2] ? (34'(pa) > bound) : (pa < 0);
    num  = bound - 34'(pa);
    den  = 34'(oa) - 34'(pa);
    db   = 33'(ob) - 33'(pb);
    un   = num[33] ? 33'(-num) : num[32:0];
    ud   = den[33] ? 33'(-den) : den[32:0];
    mdb  = db[32] ? 33'(-db) : db;
    skip = !cond || den == 0 || num == 0 || (num[33] != den[33]);
    take_other = un >= ud;
  end

  logic [65:0] product;
  crtl_pkg::unit_stat_t mul_stat, div_stat;
  logic mul_start, div_start;
  logic [65:0] div_dividend, quotient;
  logic [33:0] div_divisor, remainder;

  logic [11:0] span, kpos;
  logic signed [12:0] mdiff;
  logic signed [27:0] adv_num;
  logic [27:0] adv_mag;

  assign span    = major_end - major_start;
  assign kpos    = major_now - major_start;
  assign mdiff   = $signed({1'b0, minor_end}) - $signed({1'b0, minor_start});
  assign n_prod  = 26'($signed({1'b0, kpos}) * mdiff);
  assign adv_num = $signed({n_prod[25], n_prod, 1'b0}) + $signed({16'd0, span});
  assign adv_mag = adv_num[27] ? 28'(-adv_num) : adv_num;

  assign mul_start = (state == ST_CLIP) && !skip && !take_other;
  assign div_start = ((state == ST_CLIP_MUL) && mul_stat.done) ||
                     ((state == ST_ADV) && active && span != 0);

  always_comb begin
    if (state == ST_ADV) begin
      div_dividend = {38'd0, adv_mag};
      div_divisor  = {21'd0, span, 1'b0};
    end else begin
      div_dividend = product;
      div_divisor  = {1'b0, ud};
    end
  end

  crtl_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(un), .b(mdb),
    .product(product), .stat(mul_stat)
  );

  crtl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(quotient), .remainder(remainder), .stat(div_stat)
  );

  logic [33:0] q_round;
  logic signed [34:0] pb_new;
  assign q_round = quotient[33:0] +
                   34'({remainder, 1'b0} >= {1'b0, div_divisor});
  assign pb_new  = db[32] ? 35'(pb) - $signed({1'b0, q_round})
                          : 35'(pb) + $signed({1'b0, q_round});

  logic [27:0] adv_q;
  logic [11:0] adv_minor;
  assign adv_q     = quotient[27:0] + 28'(adv_neg && remainder != 0);
  assign adv_minor = minor_start + (adv_neg ? 12'(-adv_q) : adv_q[11:0]);

  function automatic logic [19:0] clamp_to(input logic signed [31:0] v,
                                           input logic [19:0] lim);
    if (v < 0) return '0;
    if (v > $signed({12'd0, lim})) return lim;
    return v[19:0];
  endfunction

  logic [19:0] cx1, cx2, cy1, cy2, adx, ady;
  logic reject;
  assign cx1 = clamp_to(x1, w);
  assign cx2 = clamp_to(x2, w);
  assign cy1 = clamp_to(y1, h);
  assign cy2 = clamp_to(y2, h);
  assign adx = (cx1 > cx2) ? cx1 - cx2 : cx2 - cx1;
  assign ady = (cy1 > cy2) ? cy1 - cy2 : cy2 - cy1;
  assign reject = (x1 < 0 && x2 < 0) || (y1 < 0 && y2 < 0) ||
                  (x1 > $signed({12'd0, w}) && x2 > $signed({12'd0, w})) ||
                  (y1 > $signed({12'd0, h}) && y2 > $signed({12'd0, h}));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_column <= 12'd639;
      last_row    <= 12'd479;
    end else if (cfg_we) begin
      case (cfg_index)
        crtl_pkg::REG_LAST_COLUMN: last_column <= cfg_data;
        crtl_pkg::REG_LAST_ROW:    last_row    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= 1'b0;
      horizontal  <= 1'b0;
      major_now   <= '0;
      major_start <= '0;
      major_end   <= '0;
      minor_start <= '0;
      minor_end   <= '0;
      idx         <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x1 <= s_tdata[31:0];
            y1 <= s_tdata[63:32];
            x2 <= s_tdata[95:64];
            y2 <= s_tdata[127:96];
            state <= s_tuser[0] ? ST_ADV : ST_LOAD;
          end
        end
        ST_LOAD: begin
          idx <= '0;
          if (reject) begin
            active     <= 1'b0;
            res_status <= crtl_pkg::STAT_REJECTED;
            res_mx     <= 1'b0;
            res_col    <= '0;
            res_row    <= '0;
            res_last   <= 1'b0;
            state      <= ST_OUT;
          end else begin
            state <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          if (skip || take_other) begin
            if (!skip) begin
              case (idx[1:0])
                2'd0:    begin x1 <= oa; y1 <= ob; end
                2'd1:    begin x2 <= oa; y2 <= ob; end
                2'd2:    begin y1 <= oa; x1 <= ob; end
                default: begin y2 <= oa; x2 <= ob; end
              endcase
            end
            idx <= idx + 3'd1;
            if (idx == 3'd7) state <= ST_FINISH;
          end else begin
            state <= ST_CLIP_MUL;
          end
        end
        ST_CLIP_MUL: begin
          if (mul_stat.done) state <= ST_CLIP_DIV;
        end
        ST_CLIP_DIV: begin
          if (div_stat.done) begin
            case (idx[1:0])
              2'd0:    begin x1 <= bound[31:0]; y1 <= pb_new[31:0]; end
              2'd1:    begin x2 <= bound[31:0]; y2 <= pb_new[31:0]; end
              2'd2:    begin y1 <= bound[31:0]; x1 <= pb_new[31:0]; end
              default: begin y2 <= bound[31:0]; x2 <= pb_new[31:0]; end
            endcase
            idx   <= idx + 3'd1;
            state <= (idx == 3'd7) ? ST_FINISH : ST_CLIP;
          end
        end
        ST_FINISH: begin
          horizontal <= adx > ady;
          if (adx > ady) begin
            major_start <= (cx1 < cx2) ? cx1[19:8] : cx2[19:8];
            major_now   <= (cx1 < cx2) ? cx1[19:8] : cx2[19:8];
            major_end   <= (cx1 < cx2) ? cx2[19:8] : cx1[19:8];
            minor_start <= (cx1 < cx2) ? cy1[19:8] : cy2[19:8];
            minor_end   <= (cx1 < cx2) ? cy2[19:8] : cy1[19:8];
          end else begin
            major_start <= (cy1 < cy2) ? cy1[19:8] : cy2[19:8];
            major_now   <= (cy1 < cy2) ? cy1[19:8] : cy2[19:8];
            major_end   <= (cy1 < cy2) ? cy2[19:8] : cy1[19:8];
            minor_start <= (cy1 < cy2) ? cx1[19:8] : cx2[19:8];
            minor_end   <= (cy1 < cy2) ? cx2[19:8] : cx1[19:8];
          end
          active     <= 1'b1;
          res_status <= crtl_pkg::STAT_ACCEPTED;
          res_mx     <= adx > ady;
          res_col    <= '0;
          res_row    <= '0;
          res_last   <= 1'b0;
          state      <= ST_OUT;
        end
        ST_ADV: begin
          adv_fin <= major_now >= major_end;
          if (!active) begin
            res_status <= crtl_pkg::STAT_NO_LINE;
            res_mx     <= 1'b0;
            res_col    <= '0;
            res_row    <= '0;
            res_last   <= 1'b0;
            state      <= ST_OUT;
          end else if (span == 0) begin
            res_status <= crtl_pkg::STAT_POSITION;
            res_mx     <= horizontal;
            res_col    <= horizontal ? major_now : minor_start;
            res_row    <= horizontal ? minor_start : major_now;
            res_last   <= major_now >= major_end;
            if (major_now >= major_end) active <= 1'b0;
            else major_now <= major_now + 12'd1;
            state      <= ST_OUT;
          end else begin
            state <= ST_ADV_DIV;
          end
        end
        ST_ADV_DIV: begin
          if (div_stat.done) begin
            res_status <= crtl_pkg::STAT_POSITION;
            res_mx     <= horizontal;
            res_col    <= horizontal ? major_now : adv_minor;
            res_row    <= horizontal ? adv_minor : major_now;
            res_last   <= adv_fin;
            if (adv_fin) active <= 1'b0;
            else major_now <= major_now + 12'd1;
            state      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'd0, res_row, res_col, res_mx};
            m_tlast  <= res_last;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the sign of the advance numerator for the floor correction.
  logic adv_div_go;
  assign adv_div_go = (state == ST_ADV) && active && span != 0;

  always_ff @(posedge clk) begin
    if (adv_div_go) adv_neg <= adv_num[27];
  end

  assign s_tready = (state == ST_IDLE);

  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !mul_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while idle");

  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_CLIP_DIV || state == ST_ADV_DIV))
    else $error("divider finished outside a divide state");

  assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_CLIP_MUL))
    else $error("multiplier finished outside the multiply state");

endmodule

FILE: rtl/crtl_mul.sv
module crtl_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [32:0]            a,
  input  logic [32:0]            b,
  output logic [65:0]            product,
  output crtl_pkg::unit_stat_t   stat
);

  logic [32:0] a_hold;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] sum;

  assign sum = {1'b0, product[65:33]} + (product[0] ? {1'b0, a_hold} : 34'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold  <= a;
      product <= {33'd0, b};
    end else if (busy) begin
      product <= {sum, product[32:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/crtl_div.sv
module crtl_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [65:0]            dividend,
  input  logic [33:0]            divisor,
  output logic [65:0]            quotient,
  output logic [33:0]            remainder,
  output crtl_pkg::unit_stat_t   stat
);

  logic [33:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [34:0] trial;
  logic        fits;

  assign trial = {remainder, quotient[65]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd65) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[64:0], fits};
      remainder <= fits ? 34'(trial - {1'b0, dvs}) : trial[33:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
